// ----- sv/kpat_pkg.sv -----
// Shared types and constants for the keyed priority alert table.
// Used by kpat_ctrl, kpat_dp and keyed_priority_alert_table_core.
package kpat_pkg;

    // default table size and readout bound
    localparam int TableDepth = 16;
    localparam int MaxOut     = 16;
    localparam int OutCntW    = 5;
    localparam int NumKinds   = 3;
    localparam logic [4:0] LimitReset = 5'd16;

    // operation codes
    localparam logic [2:0] FUNC_ADD    = 3'd0;
    localparam logic [2:0] FUNC_UPDATE = 3'd1;
    localparam logic [2:0] FUNC_CLEAR  = 3'd2;
    localparam logic [2:0] FUNC_CLRALL = 3'd3;
    localparam logic [2:0] FUNC_READ   = 3'd4;

    // value of register address bit 2 that selects the limit register
    localparam logic REG_LIMIT = 1'b0;

    // controller to datapath
    typedef struct packed {
        logic load;        // capture the input transaction
        logic scan_start;  // restart the slot walk
        logic scan_run;    // issue slot reads
        logic wr_level;    // rewrite priority of the matched slot
        logic wr_new;      // fill the first free slot
        logic clr_one;     // free the matched slot
        logic clr_all;     // free every slot
        logic take_clear;  // forget emitted slots
        logic take_mark;   // mark current best as emitted
        logic cnt_load;    // load the readout count
        logic cnt_dec;     // one readout result sent
        logic emit;        // load the result register
        logic emit_ok;
        logic emit_entry;
        logic emit_last;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic [2:0] func;
        logic       add_ok;
        logic       used_zero;
        logic       scan_done;
        logic       found;
        logic       out_free;
        logic       read_last;
    } status_t;

endpackage

// ----- sv/keyed_priority_alert_table_core.sv -----
// Top level of the keyed priority alert table: register port and wiring.
// Depends on kpat_pkg, kpat_ctrl and kpat_dp.
//
//  channel  | ports                                  | role
//  ---------+----------------------------------------+------------------------
//  s_       | s_valid/s_ready, func, time, kind, lvl | operation transaction
//  m_       | m_valid/m_ready, result fields         | result transactions
//  apb      | psel/penable/pwrite/paddr/pwdata/...   | per_type_limit register
//
// An admitted add, an update and a clear each walk every slot once before their result.
// Clear all, an empty read and refused or unknown operations give their result from the
// decode state, without a walk.
// A read walks the slot memory once per result, up to 16 results, since the slot memory
// has a single read port. One transaction at a time.
// Reset (aresetn, synchronous) empties the table at once. A stalled m_ready
// holds the result register and the sequencer waits before the next result.
module keyed_priority_alert_table_core #(
    parameter int TABLE_DEPTH = kpat_pkg::TableDepth
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [2:0]         s_func,
    input  logic signed [63:0] s_alert_time,
    input  logic [1:0]         s_alert_kind,
    input  logic [2:0]         s_alert_level,
    output logic               m_valid,
    input  logic               m_ready,
    output logic               m_done_ok,
    output logic               m_entry_valid,
    output logic signed [63:0] m_out_time,
    output logic [1:0]         m_out_kind,
    output logic [2:0]         m_out_level,
    output logic               m_last_item,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [2:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    kpat_pkg::cmd_t    cmd;
    kpat_pkg::status_t sts;
    logic [4:0]        limit_reg;

    // register port
    assign pready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= kpat_pkg::LimitReset;
        end else if (psel && penable && pwrite && (paddr[2] == kpat_pkg::REG_LIMIT)) begin
            limit_reg <= pwdata[4:0];
        end
    end
    assign prdata = (paddr[2] == kpat_pkg::REG_LIMIT) ? {27'd0, limit_reg} : 32'd0;

    kpat_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    kpat_dp #(
        .DEPTH (TABLE_DEPTH)
    ) u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .sts           (sts),
        .limit         (limit_reg),
        .s_func        (s_func),
        .s_alert_time  (s_alert_time),
        .s_alert_kind  (s_alert_kind),
        .s_alert_level (s_alert_level),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_done_ok     (m_done_ok),
        .m_entry_valid (m_entry_valid),
        .m_out_time    (m_out_time),
        .m_out_kind    (m_out_kind),
        .m_out_level   (m_out_level),
        .m_last_item   (m_last_item)
    );

endmodule

// ----- sv/kpat_ctrl.sv -----
// Operation sequencer for the keyed priority alert table.
// Depends on kpat_pkg (cmd_t, status_t, operation codes).
module kpat_ctrl (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  kpat_pkg::status_t sts,
    output kpat_pkg::cmd_t    cmd
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_DECODE = 2'd1;
    localparam logic [1:0] ST_SCAN   = 2'd2;
    localparam logic [1:0] ST_APPLY  = 2'd3;

    logic [1:0] state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    assign s_ready = (state_reg == ST_IDLE);

    // next state and commands
    always_comb begin
        cmd        = '0;
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_DECODE;
                end
            end
            ST_DECODE: begin
                case (sts.func) inside
                    kpat_pkg::FUNC_ADD: begin
                        if (sts.add_ok) begin
                            cmd.scan_start = 1'b1;
                            state_next     = ST_SCAN;
                        end else if (sts.out_free) begin
                            cmd.emit      = 1'b1;
                            cmd.emit_last = 1'b1;
                            state_next    = ST_IDLE;
                        end
                    end
                    kpat_pkg::FUNC_UPDATE, kpat_pkg::FUNC_CLEAR: begin
                        cmd.scan_start = 1'b1;
                        state_next     = ST_SCAN;
                    end
                    kpat_pkg::FUNC_CLRALL: begin
                        if (sts.out_free) begin
                            cmd.clr_all   = 1'b1;
                            cmd.emit      = 1'b1;
                            cmd.emit_ok   = 1'b1;
                            cmd.emit_last = 1'b1;
                            state_next    = ST_IDLE;
                        end
                    end
                    kpat_pkg::FUNC_READ: begin
                        if (!sts.used_zero) begin
                            cmd.cnt_load   = 1'b1;
                            cmd.take_clear = 1'b1;
                            cmd.scan_start = 1'b1;
                            state_next     = ST_SCAN;
                        end else if (sts.out_free) begin
                            cmd.emit      = 1'b1;
                            cmd.emit_ok   = 1'b1;
                            cmd.emit_last = 1'b1;
                            state_next    = ST_IDLE;
                        end
                    end
                    default: begin
                        if (sts.out_free) begin
                            cmd.emit      = 1'b1;
                            cmd.emit_last = 1'b1;
                            state_next    = ST_IDLE;
                        end
                    end
                endcase
            end
            ST_SCAN: begin
                cmd.scan_run = 1'b1;
                if (sts.scan_done) begin
                    state_next = ST_APPLY;
                end
            end
            ST_APPLY: begin
                if (sts.out_free) begin
                    cmd.emit = 1'b1;
                    state_next = ST_IDLE;
                    case (sts.func)
                        kpat_pkg::FUNC_ADD: begin
                            cmd.wr_level  = sts.found;
                            cmd.wr_new    = !sts.found;
                            cmd.emit_ok   = 1'b1;
                            cmd.emit_last = 1'b1;
                        end
                        kpat_pkg::FUNC_UPDATE: begin
                            cmd.wr_level  = sts.found;
                            cmd.emit_ok   = sts.found;
                            cmd.emit_last = 1'b1;
                        end
                        kpat_pkg::FUNC_CLEAR: begin
                            cmd.clr_one   = sts.found;
                            cmd.emit_ok   = sts.found;
                            cmd.emit_last = 1'b1;
                        end
                        default: begin
                            // sorted readout: one result per pass
                            cmd.emit_ok    = 1'b1;
                            cmd.emit_entry = 1'b1;
                            cmd.emit_last  = sts.read_last;
                            cmd.take_mark  = 1'b1;
                            cmd.cnt_dec    = 1'b1;
                            if (!sts.read_last) begin
                                cmd.scan_start = 1'b1;
                                state_next     = ST_SCAN;
                            end
                        end
                    endcase
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ----- sv/kpat_dp.sv -----
// Datapath: slot memory, occupancy state, slot walk and result register.
// Depends on kpat_pkg (cmd_t, status_t, constants).
module kpat_dp #(
    parameter int DEPTH = kpat_pkg::TableDepth
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  kpat_pkg::cmd_t       cmd,
    output kpat_pkg::status_t    sts,
    input  logic [4:0]          limit,
    input  logic [2:0]          s_func,
    input  logic signed [63:0]  s_alert_time,
    input  logic [1:0]          s_alert_kind,
    input  logic [2:0]          s_alert_level,
    output logic                m_valid,
    input  logic                m_ready,
    output logic                m_done_ok,
    output logic                m_entry_valid,
    output logic signed [63:0]  m_out_time,
    output logic [1:0]          m_out_kind,
    output logic [2:0]          m_out_level,
    output logic                m_last_item
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int OW = kpat_pkg::OutCntW;

    // slot memory
    logic signed [63:0] mem_time  [DEPTH];
    logic [1:0]         mem_kind  [DEPTH];
    logic [2:0]         mem_level [DEPTH];

    // captured transaction
    logic [2:0]         func_reg;
    logic signed [63:0] key_time_reg;
    logic [1:0]         key_kind_reg;
    logic [2:0]         key_level_reg;

    // occupancy
    logic [DEPTH-1:0] used_reg, taken_reg;
    logic [CW-1:0]    used_cnt_reg;
    logic [4:0]       kind_cnt_reg [kpat_pkg::NumKinds];
    logic [OW-1:0]    read_left_reg;

    // walk and read pipeline
    logic [CW-1:0]      addr_cnt_reg;
    logic               rd_vld_reg;
    logic [AW-1:0]      rd_idx_reg;
    logic signed [63:0] rd_time_reg;
    logic [1:0]         rd_kind_reg;
    logic [2:0]         rd_level_reg;

    // walk results
    logic               found_reg, free_vld_reg, best_vld_reg;
    logic [AW-1:0]      found_idx_reg, free_idx_reg, best_idx_reg;
    logic signed [63:0] best_time_reg;
    logic [1:0]         best_kind_reg;
    logic [2:0]         best_level_reg;

    logic        issue;
    logic        cand_ok, cand_better, key_match;
    logic [4:0]  kind_cnt_sel;
    logic [7:0]  used_ext;
    logic [AW-1:0] wr_addr;

    assign issue = cmd.scan_run && (addr_cnt_reg != CW'(DEPTH));

    // input capture
    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            func_reg      <= s_func;
            key_time_reg  <= s_alert_time;
            key_kind_reg  <= s_alert_kind;
            key_level_reg <= s_alert_level;
        end
    end

    // memory write and registered read
    assign wr_addr = cmd.wr_new ? free_idx_reg : found_idx_reg;

    always_ff @(posedge aclk) begin
        if (cmd.wr_new) begin
            mem_time[wr_addr] <= key_time_reg;
            mem_kind[wr_addr] <= key_kind_reg;
        end
        if (cmd.wr_new || cmd.wr_level) begin
            mem_level[wr_addr] <= key_level_reg;
        end
        if (issue) begin
            rd_time_reg  <= mem_time[addr_cnt_reg[AW-1:0]];
            rd_kind_reg  <= mem_kind[addr_cnt_reg[AW-1:0]];
            rd_level_reg <= mem_level[addr_cnt_reg[AW-1:0]];
            rd_idx_reg   <= addr_cnt_reg[AW-1:0];
        end
    end

    // walk address and read valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            addr_cnt_reg <= '0;
            rd_vld_reg   <= 1'b0;
        end else begin
            rd_vld_reg <= issue;
            if (cmd.scan_start) begin
                addr_cnt_reg <= '0;
            end else if (issue) begin
                addr_cnt_reg <= addr_cnt_reg + 1'b1;
            end
        end
    end

    // ordering: level down, time down (signed), kind up
    assign key_match = used_reg[rd_idx_reg] && (rd_time_reg == key_time_reg)
                       && (rd_kind_reg == key_kind_reg);
    assign cand_ok   = used_reg[rd_idx_reg] && !taken_reg[rd_idx_reg];
    always_comb begin
        if (rd_level_reg != best_level_reg) begin
            cand_better = rd_level_reg > best_level_reg;
        end else if (rd_time_reg != best_time_reg) begin
            cand_better = rd_time_reg > best_time_reg;
        end else begin
            cand_better = rd_kind_reg < best_kind_reg;
        end
    end

    // key match, first free slot and best remaining entry
    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.scan_start) begin
            found_reg    <= 1'b0;
            free_vld_reg <= 1'b0;
            best_vld_reg <= 1'b0;
        end else if (rd_vld_reg) begin
            if (key_match) begin
                found_reg <= 1'b1;
            end
            if (!free_vld_reg && !used_reg[rd_idx_reg]) begin
                free_vld_reg <= 1'b1;
            end
            if (cand_ok && (!best_vld_reg || cand_better)) begin
                best_vld_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_vld_reg) begin
            if (key_match) begin
                found_idx_reg <= rd_idx_reg;
            end
            if (!free_vld_reg && !used_reg[rd_idx_reg]) begin
                free_idx_reg <= rd_idx_reg;
            end
            if (cand_ok && (!best_vld_reg || cand_better)) begin
                best_idx_reg   <= rd_idx_reg;
                best_time_reg  <= rd_time_reg;
                best_kind_reg  <= rd_kind_reg;
                best_level_reg <= rd_level_reg;
            end
        end
    end

    // occupancy bits and counts
    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.clr_all) begin
            used_reg     <= '0;
            used_cnt_reg <= '0;
            for (int k = 0; k < kpat_pkg::NumKinds; k++) begin
                kind_cnt_reg[k] <= '0;
            end
        end else if (cmd.wr_new) begin
            used_reg[free_idx_reg]     <= 1'b1;
            used_cnt_reg               <= used_cnt_reg + 1'b1;
            kind_cnt_reg[key_kind_reg] <= kind_cnt_reg[key_kind_reg] + 1'b1;
        end else if (cmd.clr_one) begin
            used_reg[found_idx_reg] <= 1'b0;
            used_cnt_reg            <= used_cnt_reg - 1'b1;
            if (kind_cnt_sel != 5'd0) begin
                kind_cnt_reg[key_kind_reg] <= kind_cnt_sel - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn || cmd.take_clear) begin
            taken_reg <= '0;
        end else if (cmd.take_mark) begin
            taken_reg[best_idx_reg] <= 1'b1;
        end
    end

    // readout count, bounded by MaxOut
    assign used_ext = 8'(used_cnt_reg);
    always_ff @(posedge aclk) begin
        if (cmd.cnt_load) begin
            read_left_reg <= (used_ext >= 8'(kpat_pkg::MaxOut)) ?
                             OW'(kpat_pkg::MaxOut) : OW'(used_ext);
        end else if (cmd.cnt_dec) begin
            read_left_reg <= read_left_reg - 1'b1;
        end
    end

    // add admission check
    assign kind_cnt_sel = (key_kind_reg == 2'd3) ? 5'd0 : kind_cnt_reg[key_kind_reg];

    always_comb begin
        sts.func      = func_reg;
        sts.add_ok    = (key_kind_reg != 2'd3) && (used_cnt_reg != CW'(DEPTH))
                        && (kind_cnt_sel < limit);
        sts.used_zero = (used_cnt_reg == '0);
        sts.scan_done = (addr_cnt_reg == CW'(DEPTH)) && !rd_vld_reg;
        sts.found     = found_reg;
        sts.out_free  = !m_valid || m_ready;
        sts.read_last = (read_left_reg == OW'(1));
    end

    // result register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid <= 1'b0;
        end else if (cmd.emit) begin
            m_valid <= 1'b1;
        end else if (m_ready) begin
            m_valid <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.emit) begin
            m_done_ok     <= cmd.emit_ok;
            m_entry_valid <= cmd.emit_entry;
            m_out_time    <= cmd.emit_entry ? best_time_reg : 64'sd0;
            m_out_kind    <= cmd.emit_entry ? best_kind_reg : 2'd0;
            m_out_level   <= cmd.emit_entry ? best_level_reg : 3'd0;
            m_last_item   <= cmd.emit_last;
        end
    end

endmodule

// ----- tb/tb_keyed_priority_alert_table_core.sv -----
// Testbench for keyed_priority_alert_table_core: random and directed table operations,
// predicted by a scoreboard class holding its own copy of the alert table.
// Depends on kpat_pkg and the core RTL.
`timescale 1ns / 100ps

module tb_keyed_priority_alert_table_core;

    localparam int DEPTH = kpat_pkg::TableDepth;

    typedef struct {
        logic              ok;
        logic              entry;
        logic signed [63:0] tstamp;
        logic [1:0]        kind;
        logic [2:0]        level;
        logic              last;
    } alert_res_t;

    // alert table predictor and pending result store
    class alert_table_sb;
        bit                 used_q[DEPTH];
        logic signed [63:0] time_q[DEPTH];
        logic [1:0]         kind_q[DEPTH];
        logic [2:0]         level_q[DEPTH];
        int unsigned        kind_cnt[3];
        int unsigned        limit;
        alert_res_t         pending[$];
        int                 errors;

        function new();
            limit = 16;
            errors = 0;
            foreach (used_q[i]) used_q[i] = 0;
            foreach (kind_cnt[i]) kind_cnt[i] = 0;
        endfunction

        function void push(logic ok, logic entry, logic signed [63:0] t, logic [1:0] k,
                           logic [2:0] l, logic last);
            alert_res_t r;
            r.ok = ok; r.entry = entry; r.tstamp = t; r.kind = k; r.level = l; r.last = last;
            pending = {pending, r};
        endfunction

        function int lookup(logic signed [63:0] t, logic [1:0] k);
            for (int i = 0; i < DEPTH; i++)
                if (used_q[i] && time_q[i] == t && kind_q[i] == k) return i;
            return -1;
        endfunction

        function bit outranks(int a, int b);
            if (level_q[a] != level_q[b]) return level_q[a] > level_q[b];
            if (time_q[a] != time_q[b]) return time_q[a] > time_q[b];
            return kind_q[a] < kind_q[b];
        endfunction

        // note one accepted operation transaction
        function void note_op(logic [2:0] f, logic signed [63:0] t, logic [1:0] k,
                              logic [2:0] l);
            int fill, idx, best, n;
            bit taken[DEPTH];
            fill = 0;
            foreach (used_q[i]) if (used_q[i]) fill++;
            case (f)
                kpat_pkg::FUNC_ADD: begin
                    if (k >= 3 || fill >= DEPTH || kind_cnt[k] >= limit) begin
                        push(0, 0, 0, 0, 0, 1);
                    end else begin
                        idx = lookup(t, k);
                        if (idx >= 0) begin
                            level_q[idx] = l;
                        end else begin
                            for (int i = 0; i < DEPTH; i++)
                                if (!used_q[i]) begin
                                    used_q[i] = 1; time_q[i] = t; kind_q[i] = k;
                                    level_q[i] = l; kind_cnt[k]++;
                                    break;
                                end
                        end
                        push(1, 0, 0, 0, 0, 1);
                    end
                end
                kpat_pkg::FUNC_UPDATE: begin
                    idx = lookup(t, k);
                    if (idx >= 0) level_q[idx] = l;
                    push(idx >= 0, 0, 0, 0, 0, 1);
                end
                kpat_pkg::FUNC_CLEAR: begin
                    idx = lookup(t, k);
                    if (idx >= 0) begin
                        used_q[idx] = 0;
                        if (kind_q[idx] < 3 && kind_cnt[kind_q[idx]] > 0)
                            kind_cnt[kind_q[idx]]--;
                    end
                    push(idx >= 0, 0, 0, 0, 0, 1);
                end
                kpat_pkg::FUNC_CLRALL: begin
                    foreach (used_q[i]) used_q[i] = 0;
                    foreach (kind_cnt[i]) kind_cnt[i] = 0;
                    push(1, 0, 0, 0, 0, 1);
                end
                kpat_pkg::FUNC_READ: begin
                    n = (fill < kpat_pkg::MaxOut) ? fill : kpat_pkg::MaxOut;
                    if (n == 0) push(1, 0, 0, 0, 0, 1);
                    foreach (taken[i]) taken[i] = 0;
                    for (int r = 0; r < n; r++) begin
                        best = -1;
                        for (int i = 0; i < DEPTH; i++)
                            if (used_q[i] && !taken[i] && (best < 0 || outranks(i, best)))
                                best = i;
                        taken[best] = 1;
                        push(1, 1, time_q[best], kind_q[best], level_q[best], r == n - 1);
                    end
                end
                default: push(0, 0, 0, 0, 0, 1);
            endcase
        endfunction

        // compare one result transaction against the oldest expectation
        function void check(alert_res_t act);
            alert_res_t e;
            if (pending.size() == 0) begin
                $display("%0t unexpected result ok=%0b entry=%0b", $realtime, act.ok, act.entry);
                errors++;
                return;
            end
            e = pending.pop_front();
            if (act.ok !== e.ok) begin
                $display("%0t done_ok exp %0b got %0b", $realtime, e.ok, act.ok); errors++;
            end
            if (act.entry !== e.entry) begin
                $display("%0t entry_valid exp %0b got %0b", $realtime, e.entry, act.entry);
                errors++;
            end
            if (act.tstamp !== e.tstamp) begin
                $display("%0t out_time exp %0d got %0d", $realtime, e.tstamp, act.tstamp);
                errors++;
            end
            if (act.kind !== e.kind) begin
                $display("%0t out_kind exp %0d got %0d", $realtime, e.kind, act.kind); errors++;
            end
            if (act.level !== e.level) begin
                $display("%0t out_level exp %0d got %0d", $realtime, e.level, act.level);
                errors++;
            end
            if (act.last !== e.last) begin
                $display("%0t last_item exp %0b got %0b", $realtime, e.last, act.last); errors++;
            end
        endfunction
    endclass

    logic               aclk = 0;
    logic               aresetn = 0;
    logic               s_valid = 0;
    logic               s_ready;
    logic [2:0]         s_func = 0;
    logic signed [63:0] s_alert_time = 0;
    logic [1:0]         s_alert_kind = 0;
    logic [2:0]         s_alert_level = 0;
    logic               m_valid;
    logic               m_ready = 0;
    logic               m_done_ok, m_entry_valid, m_last_item;
    logic signed [63:0] m_out_time;
    logic [1:0]         m_out_kind;
    logic [2:0]         m_out_level;
    logic               psel = 0, penable = 0, pwrite = 0;
    logic [2:0]         paddr = 0;
    logic [31:0]        pwdata = 0;
    logic [31:0]        prdata;
    logic               pready;

    alert_table_sb sb = new();
    bit            hold_off = 0;   // long receiver stall requested
    bit            sender_done = 0;

    keyed_priority_alert_table_core dut (.*);

    always begin
        #5 aclk = 1;
        #5 aclk = 0;
    end

    // note accepted operations at the edge, before the driver changes the payload
    always @(posedge aclk) begin
        if (aresetn && s_valid && s_ready)
            sb.note_op(s_func, s_alert_time, s_alert_kind, s_alert_level);
        if (aresetn && m_valid && m_ready)
            sb.check('{m_done_ok, m_entry_valid, m_out_time, m_out_kind, m_out_level,
                       m_last_item});
    end

    function automatic int gap_len();
        return ($urandom_range(0, 9) == 0) ? $urandom_range(5, 30) : $urandom_range(0, 2);
    endfunction

    // result side: random ready, with a long hold-off on request
    initial begin
        int g;
        @(posedge aclk iff aresetn);
        forever begin
            if (hold_off) begin
                m_ready <= 0;
                repeat (400) @(posedge aclk);
                hold_off = 0;
            end
            g = ($urandom_range(0, 3) == 0) ? gap_len() : 0;
            m_ready <= (g == 0);
            @(posedge aclk);
            if (g > 1) repeat (g - 1) @(posedge aclk);
        end
    end

    task automatic send_op(logic [2:0] f, logic signed [63:0] t, logic [1:0] k,
                           logic [2:0] l, bit gaps);
        int g;
        g = gaps ? gap_len() : 0;
        if (g > 0) begin
            s_valid <= 0;
            repeat (g) @(posedge aclk);
        end
        s_valid <= 1;
        s_func <= f; s_alert_time <= t; s_alert_kind <= k; s_alert_level <= l;
        @(posedge aclk iff s_ready);
    endtask

    task automatic drain();
        s_valid <= 0;
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (DEPTH * 4 + 20) @(posedge aclk);
    endtask

    task automatic write_limit(logic [4:0] v);
        psel <= 1; penable <= 0; pwrite <= 1; paddr <= 0; pwdata <= {27'd0, v};
        @(posedge aclk);
        penable <= 1;
        @(posedge aclk);
        psel <= 0; penable <= 0; pwrite <= 0;
        sb.limit = v;
    endtask

    function automatic logic signed [63:0] rand_time(int pool);
        logic signed [63:0] t;
        case ($urandom_range(0, 3))
            0: t = {$urandom, $urandom};
            default: t = int'($urandom_range(0, pool)) - pool / 2;
        endcase
        return t;
    endfunction

    task automatic rand_phase(int cnt, int pool);
        int r;
        logic [2:0] f;
        for (int i = 0; i < cnt; i++) begin
            r = $urandom_range(0, 99);
            if (r < 45) f = kpat_pkg::FUNC_ADD;
            else if (r < 60) f = kpat_pkg::FUNC_UPDATE;
            else if (r < 75) f = kpat_pkg::FUNC_CLEAR;
            else if (r < 80) f = kpat_pkg::FUNC_CLRALL;
            else if (r < 95) f = kpat_pkg::FUNC_READ;
            else f = 3'($urandom_range(5, 7));
            send_op(f, rand_time(pool), ($urandom_range(0, 15) == 0) ? 2'd3 :
                    2'($urandom_range(0, 2)), 3'($urandom), 1);
        end
    endtask

    // stimulus
    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);

        // directed: empty read, extremes, duplicate, type three, unknown ops
        send_op(kpat_pkg::FUNC_READ, 0, 0, 0, 0);
        send_op(kpat_pkg::FUNC_ADD, 64'sh8000_0000_0000_0000, 0, 7, 0);
        send_op(kpat_pkg::FUNC_ADD, 64'sh7FFF_FFFF_FFFF_FFFF, 1, 7, 0);
        send_op(kpat_pkg::FUNC_ADD, -1, 2, 0, 0);
        send_op(kpat_pkg::FUNC_ADD, -1, 0, 0, 0);
        send_op(kpat_pkg::FUNC_ADD, -1, 1, 0, 0);
        send_op(kpat_pkg::FUNC_ADD, -1, 2, 5, 0);
        send_op(kpat_pkg::FUNC_ADD, 5, 3, 3, 0);
        send_op(kpat_pkg::FUNC_UPDATE, 5, 3, 3, 0);
        send_op(kpat_pkg::FUNC_CLEAR, 5, 3, 3, 0);
        send_op(kpat_pkg::FUNC_UPDATE, -1, 0, 7, 0);
        send_op(kpat_pkg::FUNC_UPDATE, 99, 0, 7, 0);
        send_op(kpat_pkg::FUNC_READ, 0, 0, 0, 0);
        send_op(kpat_pkg::FUNC_CLEAR, -1, 1, 0, 0);
        send_op(kpat_pkg::FUNC_CLEAR, 99, 1, 0, 0);
        send_op(3'd5, 1, 1, 1, 0);
        send_op(3'd6, 1, 1, 1, 0);
        send_op(3'd7, 1, 1, 1, 0);
        send_op(kpat_pkg::FUNC_READ, 0, 0, 0, 0);
        send_op(kpat_pkg::FUNC_CLRALL, 0, 0, 0, 0);
        send_op(kpat_pkg::FUNC_READ, 0, 0, 0, 0);
        drain();

        // fill the table while the receiver stalls, then read it all back
        hold_off = 1;
        for (int i = 0; i < 18; i++)
            send_op(kpat_pkg::FUNC_ADD, rand_time(1000), 2'(i % 3), 3'($urandom), 0);
        send_op(kpat_pkg::FUNC_READ, 0, 0, 0, 0);
        drain();

        // limit zero: every add refused
        write_limit(0);
        rand_phase(10, 20);
        drain();
        write_limit(1);
        send_op(kpat_pkg::FUNC_CLRALL, 0, 0, 0, 0);
        rand_phase(15, 8);
        drain();
        write_limit(5'd31);
        rand_phase(20, 40);
        drain();
        write_limit(4);
        rand_phase(15, 16);
        send_op(kpat_pkg::FUNC_READ, 0, 0, 0, 0);
        drain();

        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial begin
        #20ms;
        $display("TB_ERROR");
        $finish;
    end

endmodule

// ----- files.f -----
sv/kpat_pkg.sv
sv/kpat_ctrl.sv
sv/kpat_dp.sv
sv/keyed_priority_alert_table_core.sv
tb/tb_keyed_priority_alert_table_core.sv
